[src/rskg_pkg.sv]
package rskg_pkg;

  // Float constants
  localparam logic [31:0] QNAN     = 32'h7FC0_0000;
  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
  localparam logic [30:0] INF_MAG  = 31'h7F80_0000;

  // Default lane count of a float operator unit
  localparam int LANES_DEF = 1;
  localparam int SIDE_DEF  = 32;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_SORT_MODE    = 3'd0,
    CFG_RENDER_GROUP = 3'd1,
    CFG_CAMERA_X     = 3'd2,
    CFG_CAMERA_Y     = 3'd3,
    CFG_CAMERA_Z     = 3'd4,
    CFG_VIEW_DIR_X   = 3'd5,
    CFG_VIEW_DIR_Y   = 3'd6,
    CFG_VIEW_DIR_Z   = 3'd7
  } cfg_idx_e;

  // Sort modes
  typedef enum logic [3:0] {
    MODE_GROUP = 4'd0,
    MODE_BACK_TO_FRONT = 4'd1,
    MODE_FRONT_TO_BACK = 4'd2,
    MODE_POS_X = 4'd3,
    MODE_NEG_X = 4'd4,
    MODE_POS_Y = 4'd5,
    MODE_NEG_Y = 4'd6,
    MODE_POS_Z = 4'd7,
    MODE_NEG_Z = 4'd8
  } mode_e;

  // Float operator kind
  typedef enum logic [0:0] {
    FOP_ADD = 1'b0,
    FOP_MUL = 1'b1
  } fop_e;

  // Unrounded result: value = (-1)^sign * sig * 2^e, or a special pattern
  typedef struct packed {
    logic                special;
    logic [31:0]         spec_val;
    logic                sign;
    logic signed [10:0]  e;
    logic [47:0]         sig;
  } op_t;

  function automatic logic is_nan(logic [31:0] f);
    return f[30:0] > INF_MAG;
  endfunction

  function automatic logic is_inf(logic [31:0] f);
    return f[30:0] == INF_MAG;
  endfunction

  // Align and add/subtract significands with guard, round and sticky bits
  function automatic op_t add_align(logic [31:0] a, logic [31:0] b);
    op_t         r;
    logic        swap;
    logic        sub;
    logic [31:0] x;
    logic [31:0] y;
    logic [7:0]  ex;
    logic [7:0]  ey;
    logic [7:0]  d;
    logic [26:0] mx;
    logic [26:0] my;
    logic [26:0] ys;
    logic [27:0] sum;
    r = '0;
    swap = b[30:0] > a[30:0];
    x = swap ? b : a;
    y = swap ? a : b;
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx = {x[30:23] != 8'd0, x[22:0], 3'b000};
    my = {y[30:23] != 8'd0, y[22:0], 3'b000};
    d = ex - ey;
    if (d >= 8'd27) begin
      ys = {26'd0, |my};
    end else begin
      ys = (my >> d) | {26'd0, |(my & ((27'd1 << d) - 27'd1))};
    end
    sub = x[31] ^ y[31];
    sum = sub ? ({1'b0, mx} - {1'b0, ys}) : ({1'b0, mx} + {1'b0, ys});
    // exact cancellation gives +0
    r.sign = (sub && (sum == 28'd0)) ? 1'b0 : x[31];
    r.e = $signed({3'b000, ex}) - 11'sd153;
    r.sig = {20'd0, sum};
    // specials
    if (is_nan(a) || is_nan(b) || (is_inf(a) && is_inf(b) && (a[31] != b[31]))) begin
      r.special = 1'b1;
      r.spec_val = QNAN;
    end else if (is_inf(a)) begin
      r.special = 1'b1;
      r.spec_val = a;
    end else if (is_inf(b)) begin
      r.special = 1'b1;
      r.spec_val = b;
    end
    return r;
  endfunction

  // Full significand product
  function automatic op_t mul_prep(logic [31:0] a, logic [31:0] b);
    op_t        r;
    logic [7:0] ea;
    logic [7:0] eb;
    logic [23:0] ma;
    logic [23:0] mb;
    r = '0;
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    r.sign = a[31] ^ b[31];
    r.e = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd300;
    r.sig = {24'd0, ma} * {24'd0, mb};
    if (is_nan(a) || is_nan(b)) begin
      r.special = 1'b1;
      r.spec_val = QNAN;
    end else if (is_inf(a) || is_inf(b)) begin
      r.special = 1'b1;
      if ((a[30:0] == 31'd0) || (b[30:0] == 31'd0)) begin
        r.spec_val = QNAN;
      end else begin
        r.spec_val = {r.sign, INF_MAG};
      end
    end
    return r;
  endfunction

  // Normalize and round to nearest even, subnormals kept
  function automatic logic [31:0] round_pack(op_t v);
    logic [5:0]         p;
    logic signed [10:0] b;
    logic signed [10:0] sh;
    logic signed [10:0] s2;
    logic signed [10:0] bm1;
    logic [5:0]         lsh;
    logic [47:0]        shifted;
    logic [47:0]        rem;
    logic [47:0]        half;
    logic [24:0]        m;
    logic [30:0]        base;
    logic [31:0]        res;
    p = '0;
    for (int i = 0; i < 48; i++) begin
      if (v.sig[i]) p = 6'(i);
    end
    b = $signed({5'd0, p}) + v.e + 11'sd127;
    sh = $signed({5'd0, p}) - 11'sd23;
    s2 = -11'sd149 - v.e;
    if (s2 > sh) sh = s2;
    lsh = 6'(-sh);
    shifted = v.sig >> sh[5:0];
    rem = v.sig & ((48'd1 << sh[5:0]) - 48'd1);
    half = 48'd1 << (sh[5:0] - 6'd1);
    if (sh <= 11'sd0) begin
      m = 25'(v.sig << lsh);
    end else if (sh > 11'sd48) begin
      m = '0;
    end else if (sh == 11'sd48) begin
      m = {24'd0, v.sig[47] & (|v.sig[46:0])};
    end else begin
      m = 25'(shifted) +
          (((rem > half) || ((rem == half) && shifted[0])) ? 25'd1 : 25'd0);
    end
    bm1 = b - 11'sd1;
    base = (b >= 11'sd1) ? {bm1[7:0], 23'd0} : 31'd0;
    if (v.sig == 48'd0) begin
      res = {v.sign, 31'd0};
    end else if (b >= 11'sd255) begin
      res = {v.sign, INF_MAG};
    end else begin
      res = {v.sign, base + {6'd0, m}};
    end
    return res;
  endfunction

  // Map a word so that unsigned order follows float (sign-magnitude) order
  function automatic logic [31:0] order_map(logic [31:0] w);
    return w[31] ? ~w : {~w[31], w[30:0]};
  endfunction

endpackage

[src/rskg_fop.sv]
// Two-stage float operator over parallel lanes: prepare, then round.
module rskg_fop #(
  parameter int              LANES  = rskg_pkg::LANES_DEF,
  parameter int              SIDE_W = rskg_pkg::SIDE_DEF,
  parameter rskg_pkg::fop_e  OP     = rskg_pkg::FOP_ADD
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [LANES-1:0][31:0]       a,
  input  logic [LANES-1:0][31:0]       b,
  input  logic [SIDE_W-1:0]            side_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [LANES-1:0][31:0]       res,
  output logic [SIDE_W-1:0]            side_out
);

  rskg_pkg::op_t          op_d [LANES];
  rskg_pkg::op_t          op_q [LANES];
  logic [LANES-1:0][31:0] res_d;
  logic [SIDE_W-1:0]      side_q;
  logic                   v1;
  logic                   en1;
  logic                   en2;

  // stage enables: a stage moves when empty or when its successor moves
  assign en2      = !out_valid || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // prepare
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (OP == rskg_pkg::FOP_MUL) begin
        op_d[i] = rskg_pkg::mul_prep(a[i], b[i]);
      end else begin
        op_d[i] = rskg_pkg::add_align(a[i], b[i]);
      end
    end
  end

  // round
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      res_d[i] = op_q[i].special ? op_q[i].spec_val : rskg_pkg::round_pack(op_q[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      op_q   <= op_d;
      side_q <= side_in;
    end
    if (en2) begin
      res      <= res_d;
      side_out <= side_q;
    end
  end

endmodule

[src/rskg_keymap.sv]
// Final word select, order mapping and output register.
module rskg_keymap (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] dot,
  input  logic [31:0] pass_word,
  input  logic [3:0]  sort_mode,
  input  logic [31:0] render_group,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] sort_key
);

  logic        en;
  logic [31:0] w;

  assign en       = !out_valid || !out_stall;
  assign in_ready = en;

  // select distance or pass-through word
  always_comb begin
    unique case (sort_mode)
      rskg_pkg::MODE_BACK_TO_FRONT: w = dot ^ rskg_pkg::SIGN_BIT;
      rskg_pkg::MODE_FRONT_TO_BACK: w = dot;
      default:                      w = pass_word;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) sort_key <= {render_group, rskg_pkg::order_map(w)};
  end

endmodule

[src/render_sort_key_generator_core.sv]
// Channel   Direction  Handshake            Payload
// in        sink       in_valid/in_stall    pos_x, pos_y, pos_z, group_value
// out       source     out_valid/out_stall  sort_key
// cfg       sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item enters per cycle while no stall holds the pipe; the path is four two-stage float units
// (subtract, multiply, two adds, each prepare then round) and the output register.
// Synchronous reset clears all valid bits and the configuration registers.
// Stalls back up stage by stage; an empty stage still accepts, so bubbles close up.
// cfg_ready is always high.
module render_sort_key_generator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        pos_x,
  input  logic [31:0]        pos_y,
  input  logic [31:0]        pos_z,
  input  logic signed [31:0] group_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        sort_key,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [3:0]        sort_mode;
  logic [31:0]       render_group;
  logic [2:0][31:0]  cam;
  logic [2:0][31:0]  dir;

  logic [2:0][31:0]  neg_cam;
  logic [31:0]       pass_word;

  logic              diff_valid, diff_ready;
  logic [2:0][31:0]  diff;
  logic [31:0]       diff_pass;
  logic              prod_valid, prod_ready;
  logic [2:0][31:0]  prod;
  logic [31:0]       prod_pass;
  logic              s01_valid, s01_ready;
  logic [0:0][31:0]  s01;
  logic [63:0]       s01_side;
  logic              dot_valid, dot_ready;
  logic [0:0][31:0]  dot;
  logic [31:0]       dot_pass;
  logic              in_ready;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_mode    <= '0;
      render_group <= '0;
      cam          <= '0;
      dir          <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rskg_pkg::cfg_idx_e'(cfg_index))
        rskg_pkg::CFG_SORT_MODE:    sort_mode    <= cfg_data[3:0];
        rskg_pkg::CFG_RENDER_GROUP: render_group <= cfg_data;
        rskg_pkg::CFG_CAMERA_X:     cam[0]       <= cfg_data;
        rskg_pkg::CFG_CAMERA_Y:     cam[1]       <= cfg_data;
        rskg_pkg::CFG_CAMERA_Z:     cam[2]       <= cfg_data;
        rskg_pkg::CFG_VIEW_DIR_X:   dir[0]       <= cfg_data;
        rskg_pkg::CFG_VIEW_DIR_Y:   dir[1]       <= cfg_data;
        rskg_pkg::CFG_VIEW_DIR_Z:   dir[2]       <= cfg_data;
      endcase
    end
  end

  // word for the non-distance modes, carried alongside the float pipe
  always_comb begin
    unique case (sort_mode)
      rskg_pkg::MODE_GROUP: pass_word = group_value;
      rskg_pkg::MODE_POS_X: pass_word = pos_x;
      rskg_pkg::MODE_NEG_X: pass_word = pos_x ^ rskg_pkg::SIGN_BIT;
      rskg_pkg::MODE_POS_Y: pass_word = pos_y;
      rskg_pkg::MODE_NEG_Y: pass_word = pos_y ^ rskg_pkg::SIGN_BIT;
      rskg_pkg::MODE_POS_Z: pass_word = pos_z;
      rskg_pkg::MODE_NEG_Z: pass_word = pos_z ^ rskg_pkg::SIGN_BIT;
      default:              pass_word = '0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_cam[i] = cam[i] ^ rskg_pkg::SIGN_BIT;
    end
  end

  assign in_stall = !in_ready;

  // pos - cam
  rskg_fop #(.LANES(3), .SIDE_W(32), .OP(rskg_pkg::FOP_ADD)) u_diff (
    .clk, .rst,
    .in_valid (in_valid),   .in_ready (in_ready),
    .a        ({pos_z, pos_y, pos_x}),
    .b        (neg_cam),
    .side_in  (pass_word),
    .out_valid(diff_valid), .out_ready(diff_ready),
    .res      (diff),       .side_out (diff_pass)
  );

  // (pos - cam) * dir
  rskg_fop #(.LANES(3), .SIDE_W(32), .OP(rskg_pkg::FOP_MUL)) u_prod (
    .clk, .rst,
    .in_valid (diff_valid), .in_ready (diff_ready),
    .a        (diff),       .b        (dir),
    .side_in  (diff_pass),
    .out_valid(prod_valid), .out_ready(prod_ready),
    .res      (prod),       .side_out (prod_pass)
  );

  // x + y, z rides along
  rskg_fop #(.LANES(1), .SIDE_W(64), .OP(rskg_pkg::FOP_ADD)) u_sum01 (
    .clk, .rst,
    .in_valid (prod_valid), .in_ready (prod_ready),
    .a        (prod[0]),    .b        (prod[1]),
    .side_in  ({prod[2], prod_pass}),
    .out_valid(s01_valid),  .out_ready(s01_ready),
    .res      (s01),        .side_out (s01_side)
  );

  // (x + y) + z
  rskg_fop #(.LANES(1), .SIDE_W(32), .OP(rskg_pkg::FOP_ADD)) u_sum (
    .clk, .rst,
    .in_valid (s01_valid),  .in_ready (s01_ready),
    .a        (s01),        .b        (s01_side[63:32]),
    .side_in  (s01_side[31:0]),
    .out_valid(dot_valid),  .out_ready(dot_ready),
    .res      (dot),        .side_out (dot_pass)
  );

  rskg_keymap u_keymap (
    .clk, .rst,
    .in_valid    (dot_valid),
    .in_ready    (dot_ready),
    .dot         (dot[0]),
    .pass_word   (dot_pass),
    .sort_mode   (sort_mode),
    .render_group(render_group),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sort_key    (sort_key)
  );

endmodule

[src/rskg_checker.sv]
module rskg_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [31:0]        pos_x,
  input logic [31:0]        pos_y,
  input logic [31:0]        pos_z,
  input logic signed [31:0] group_value,
  input logic               out_valid,
  input logic               out_stall,
  input logic [63:0]        sort_key,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [2:0]         cfg_index,
  input logic [31:0]        cfg_data
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sort_key))
    else $error("stalled sort_key changed");

  // input backs up only when the whole pipe is full behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

  // config port never blocks
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write blocked");

endmodule

bind render_sort_key_generator_core rskg_checker u_rskg_checker (.*);
